[rtl/hpg_pkg.sv]
// Shared types and constants for the Heap permutation generator.
package hpg_pkg;

  localparam int MAX_ELEMENTS_DEF = 8;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam logic [3:0] PERM_LENGTH_RESET = 4'd8;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_NEXT    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_EMIT,
    ST_EXH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic scan_init;
    logic scan_step;
    logic swap_rd;
    logic swap_wa;
    logic swap_wb;
    logic emit;
    logic emit_exh;
    logic set_done;
  } hpg_cmd_t;

  typedef struct packed {
    logic started;
    logic done;
    logic scan_end;
    logic scan_hit;
    logic emit_last;
    logic out_free;
  } hpg_status_t;

endpackage

[rtl/hpg_ctrl.sv]
// Controller state machine: sequences load, restart, scan, swap and emit steps.
module hpg_ctrl import hpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  mode,
  input  hpg_status_t st,
  output hpg_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  mode_t       mode_dec;

  assign mode_dec = mode_t'(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && mode_dec == MODE_NEXT) begin
          if (st.done) begin
            state_next = ST_EXH;
          end else if (!st.started) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (st.scan_end) begin
          state_next = ST_EXH;
        end else if (st.scan_hit) begin
          state_next = ST_SWAP_WA;
        end
      end
      ST_SWAP_WA: state_next = ST_SWAP_WB;
      ST_SWAP_WB: state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free && st.emit_last) state_next = ST_IDLE;
      end
      ST_EXH: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (mode_dec)
            MODE_LOAD:    cmd.load    = 1'b1;
            MODE_RESTART: cmd.restart = 1'b1;
            MODE_NEXT: begin
              if (!st.done && !st.started) cmd.start = 1'b1;
              else if (!st.done) cmd.scan_init = 1'b1;
            end
            default: ;  // unused mode: dropped
          endcase
        end
      end
      ST_SCAN: begin
        if (st.scan_end) cmd.set_done = 1'b1;
        else if (st.scan_hit) cmd.swap_rd = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      ST_SWAP_WA: cmd.swap_wa  = 1'b1;
      ST_SWAP_WB: cmd.swap_wb  = 1'b1;
      ST_EMIT:    cmd.emit     = st.out_free;
      ST_EXH:     cmd.emit_exh = st.out_free;
      default: ;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input taken outside idle");

  a_swap_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_rd |=> cmd.swap_wa ##1 cmd.swap_wb)
    else $error("swap sequence broken");

  a_no_emit_while_scanning: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !(cmd.emit || cmd.emit_exh))
    else $error("beat emitted during scan");

endmodule

[rtl/hpg_dp.sv]
// Datapath: element memory, swap counters, scan and emit indexes, output register.
module hpg_dp import hpg_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  hpg_cmd_t    cmd,
  output hpg_status_t st,
  input  logic [2:0]  slot,
  input  logic [31:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [31:0] element,
  output logic [2:0]  position,
  output logic        last,
  output logic        exhausted
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int IW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  logic [SW-1:0] mem [MAX_ELEMENTS];
  logic [AW-1:0] cnt [MAX_ELEMENTS];

  logic [3:0]    perm_length;
  logic          started, done;
  logic [IW-1:0] idx, pos, n_eff;
  logic [AW-1:0] swap_a;
  logic [SW-1:0] rd_a, rd_b;

  logic [AW-1:0] ra, rb, cur_cnt, wr_addr;
  logic [SW-1:0] wr_data;
  logic          wr_en, slot_ok;
  logic [4:0]    pl_w;

  logic          out_valid;
  logic [SW-1:0] out_elem;
  logic [2:0]    out_pos;
  logic          out_last, out_exh;

  assign cfg_ready = 1'b1;

  // length 0 acts as 1, above the array depth acts as the depth
  always_comb begin
    pl_w = 5'(perm_length);
    if (pl_w == 5'd0) n_eff = IW'(1);
    else if (pl_w > 5'(MAX_ELEMENTS)) n_eff = IW'(MAX_ELEMENTS);
    else n_eff = IW'(pl_w);
  end

  assign slot_ok = (5'(slot) < 5'(MAX_ELEMENTS));
  assign cur_cnt = cnt[AW'(idx)];
  assign rb      = AW'(idx);
  // odd level swaps with the counter slot, even level with slot 0
  assign ra      = cmd.emit ? AW'(pos) : (idx[0] ? cur_cnt : '0);

  assign st.started   = started;
  assign st.done      = done;
  assign st.scan_end  = (idx == n_eff);
  assign st.scan_hit  = (IW'(cur_cnt) < idx);
  assign st.emit_last = (IW'(pos + IW'(1)) == n_eff);
  assign st.out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= PERM_LENGTH_RESET;
    end else if (cfg_valid) begin
      perm_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      done    <= 1'b0;
      for (int k = 0; k < MAX_ELEMENTS; k++) cnt[k] <= '0;
    end else begin
      if (cmd.restart) begin
        started <= 1'b0;
        done    <= 1'b0;
        for (int k = 0; k < MAX_ELEMENTS; k++) cnt[k] <= '0;
      end
      if (cmd.start) started <= 1'b1;
      if (cmd.set_done) done <= 1'b1;
      if (cmd.scan_step) cnt[AW'(idx)] <= '0;
      if (cmd.swap_rd) cnt[AW'(idx)] <= cur_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) idx <= '0;
    else if (cmd.scan_step) idx <= idx + IW'(1);
    if (cmd.start || cmd.swap_wb) pos <= '0;
    else if (cmd.emit) pos <= pos + IW'(1);
  end

  // element memory: one write port, two registered read ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rb;
    wr_data = rd_a;
    if (cmd.load && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = AW'(slot);
      wr_data = value[SW-1:0];
    end else if (cmd.swap_wa) begin
      wr_en   = 1'b1;
      wr_addr = swap_a;
      wr_data = rd_b;
    end else if (cmd.swap_wb) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.swap_rd) begin
      rd_a   <= mem[ra];
      rd_b   <= mem[rb];
      swap_a <= ra;
    end
    if (cmd.emit) begin
      out_elem <= mem[ra];
      out_pos  <= 3'(pos);
      out_last <= st.emit_last;
      out_exh  <= 1'b0;
    end else if (cmd.emit_exh) begin
      out_elem <= '0;
      out_pos  <= '0;
      out_last <= 1'b1;
      out_exh  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_exh) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid  = out_valid;
  assign element   = 32'(out_elem);
  assign position  = out_pos;
  assign last      = out_last;
  assign exhausted = out_exh;

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_exh) |-> (!out_valid || m_tready))
    else $error("output register overwritten");

  a_swap_distinct: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_wa |-> (swap_a != AW'(idx)))
    else $error("swap of a slot with itself");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    (idx < IW'(MAX_ELEMENTS)) |-> (IW'(cur_cnt) <= idx))
    else $error("swap counter above its level");

  a_exh_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_exh) |-> (out_last && out_pos == 3'd0))
    else $error("malformed exhausted beat");

endmodule

[rtl/heap_permutation_generator_top.sv]
// Top level of the Heap permutation generator: stream ports, controller and datapath.
//
//  channel   dir  signals                         content
//  s_*       in   tvalid tready tdata tuser       load / restart / next request
//  m_*       out  tvalid tready tdata tlast tuser one element of an ordering
//  cfg_*     in   valid ready data                perm_length write
//
// The first ordering after a restart is emitted directly. A later request scans up to n
// counter levels, one per cycle, swaps through the single write port (ST_SWAP_WA, then
// ST_SWAP_WB), then emits n beats; it emits an exhausted beat when the levels run out or
// once exhausted. Synchronous reset clears counters, flags and perm_length (to 8); element
// slots hold no value until loaded. m_tready stalls hold the emit sequence; the final beat
// waits in the output register while the next input is taken.
module heap_permutation_generator_top import hpg_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[2:0], value[34:3], zero pad[39:35]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // element[31:0], position[34:32], zero pad[39:35]
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // exhausted[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  hpg_cmd_t    cmd;
  hpg_status_t st;
  logic [31:0] element;
  logic [2:0]  position;
  logic        exhausted;

  hpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .st       (st),
    .cmd      (cmd)
  );

  hpg_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .slot      (s_tdata[2:0]),
    .value     (s_tdata[34:3]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .element   (element),
    .position  (position),
    .last      (m_tlast),
    .exhausted (exhausted)
  );

  assign m_tdata = {5'd0, position, element};
  assign m_tuser = exhausted;

endmodule
